>>> src/threshold_alarm_report_scheduler_top_macros.svh
// assertion macros for the threshold alarm report scheduler
// no dependencies; included by the top level
`ifndef THRESHOLD_ALARM_REPORT_SCHEDULER_TOP_MACROS_SVH
`define THRESHOLD_ALARM_REPORT_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TARS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tars assertion failed");

// next-cycle implication
`define TARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tars assertion failed");

`else

`define TARS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define TARS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> src/tars_pkg.sv
// shared types, constants and the rate factor table for the scheduler
// no dependencies
package tars_pkg;

    localparam int unsigned PERIOD_W   = 16;
    localparam int unsigned FACTOR_W   = 10;
    localparam int unsigned PRODUCT_W  = PERIOD_W + FACTOR_W;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned FORCE_LOAD = 50000;

    typedef logic [3:0] rate_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD     = 3'd0,
        CFG_RATE_SELECT   = 3'd1,
        CFG_ACQ_PERIOD    = 3'd2,
        CFG_PERSIST_COUNT = 3'd3,
        CFG_CHECK_WINDOW  = 3'd4
    } cfg_index_t;

    // fast alert interval uses the 60x entry of the table
    localparam rate_code_t RATE_CODE_FAST = 4'd3;
    localparam rate_code_t RATE_CODE_MAX  = 4'd7;

    function automatic logic [FACTOR_W-1:0] rate_factor(input logic [2:0] code);
        logic [FACTOR_W-1:0] f;
        case (code)
            3'd0:    f = 10'd0;
            3'd1:    f = 10'd15;
            3'd2:    f = 10'd30;
            3'd3:    f = 10'd60;
            3'd4:    f = 10'd300;
            3'd5:    f = 10'd600;
            3'd6:    f = 10'd900;
            default: f = 10'd0;
        endcase
        return f;
    endfunction

endpackage

>>> src/tars_interval.sv
// report interval lookup: rate code to saturated period * factor
// depends on tars_pkg
module tars_interval #(
    parameter int COUNTER_BITS = 16
) (
    input  logic [3:0]                      code,
    input  logic [tars_pkg::PERIOD_W-1:0]   period,
    output logic [COUNTER_BITS-1:0]         interval,
    output logic                            keep
);

    localparam int unsigned WIDE_W = tars_pkg::PRODUCT_W + COUNTER_BITS;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};

    logic [tars_pkg::PRODUCT_W-1:0] product;
    logic [WIDE_W-1:0]              product_wide;

    always_comb
    begin
        product      = tars_pkg::PRODUCT_W'(period) *
                       tars_pkg::PRODUCT_W'(tars_pkg::rate_factor(code[2:0]));
        product_wide = WIDE_W'(product);
        keep         = code[3];
        if (code == tars_pkg::RATE_CODE_MAX) begin
            interval = CNT_MAX;
        end else if (product_wide > WIDE_W'(CNT_MAX)) begin
            interval = CNT_MAX;
        end else begin
            interval = product_wide[COUNTER_BITS-1:0];
        end
    end

endmodule

>>> src/threshold_alarm_report_scheduler_top.sv
// threshold alarm report scheduler: tick pipeline, config registers, counters
// depends on tars_pkg, tars_interval and the assertion macro header
//
// usage
// - input channel (in_valid / in_ready / low_band_level): one beat per timer
//   tick, carrying the current averaged low-band reading
// - output channel (out_valid / out_ready / acquire / transmit / report_alert /
//   alert_now): exactly one beat per input beat, in order
// - config port (cfg_we / cfg_index / cfg_wdata): write-only, takes effect at
//   the clock edge where cfg_we is high; write only while no tick is in flight
// - a beat moves from the input register to the output register once the latter is
//   empty or draining; throughput: one tick per cycle while out_ready is high;
//   the input register feeds one layer of counter/compare logic into the output
//   register, and the scheduler state advances exactly when a tick moves into it
// - stall: while out_ready is low the output beat holds, the input register
//   still takes one more beat, then in_ready drops until the output drains
// - reset (rst_n low, async): config registers go to their defaults, all
//   counters clear, the first-report flag is set, both pipeline stages empty
// - derived intervals are registered from the config registers, so a write
//   reaches them through the config register and then the interval register
`include "threshold_alarm_report_scheduler_top_macros.svh"

module threshold_alarm_report_scheduler_top #(
    parameter int COUNTER_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [15:0]                         low_band_level,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                acquire,
    output logic                                transmit,
    output logic                                report_alert,
    output logic                                alert_now,

    input  logic                                cfg_we,
    input  logic [tars_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tars_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // compare width: counters against 16-bit config values
    localparam int unsigned CMP_W = (COUNTER_BITS > 16) ? COUNTER_BITS : 16;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = {COUNTER_BITS{1'b1}};
    localparam logic [COUNTER_BITS-1:0] CNT_ONE = COUNTER_BITS'(1);
    localparam longint unsigned CNT_MAX_L = (64'd1 << COUNTER_BITS) - 64'd1;
    localparam logic [COUNTER_BITS-1:0] FORCE_VAL =
        (longint'(tars_pkg::FORCE_LOAD) > CNT_MAX_L) ? CNT_MAX
                                                     : COUNTER_BITS'(tars_pkg::FORCE_LOAD);

    // config registers
    logic [15:0] threshold_reg,     threshold_next;
    logic [3:0]  rate_select_reg,   rate_select_next;
    logic [15:0] acq_period_reg,    acq_period_next;
    logic [7:0]  persist_count_reg, persist_count_next;
    logic [15:0] check_window_reg,  check_window_next;

    // scheduler state
    logic [COUNTER_BITS-1:0] acq_counter_reg,     acq_counter_next;
    logic [COUNTER_BITS-1:0] report_counter_reg,  report_counter_next;
    logic [COUNTER_BITS-1:0] report_interval_reg, report_interval_next;
    logic [COUNTER_BITS-1:0] persist_counter_reg, persist_counter_next;
    logic [COUNTER_BITS-1:0] window_counter_reg,  window_counter_next;
    logic report_pending_reg, report_pending_next;
    logic first_report_reg,   first_report_next;
    logic check_pending_reg,  check_pending_next;
    logic alert_reg,          alert_next;

    // pipeline
    logic        s1_valid_reg, s1_valid_next;
    logic [15:0] level_reg;
    logic        out_valid_reg, out_valid_next;
    logic        acquire_reg, transmit_reg, report_alert_reg, alert_now_reg;
    logic        acquire_c, transmit_c, report_alert_c;
    logic        in_fire, step;

    // derived intervals
    logic [COUNTER_BITS-1:0] wr_ival, rate_ival, fast_ival;
    logic                    wr_keep, rate_keep, fast_keep;
    logic [COUNTER_BITS-1:0] rate_ival_reg, fast_ival_reg;
    logic                    rate_keep_reg;

    // scratch for the tick update
    logic [COUNTER_BITS-1:0] acq_inc, rc_inc, pc_inc, wc_inc;

    // interval for a freshly written rate code
    tars_interval #(.COUNTER_BITS(COUNTER_BITS)) u_wr_ival (
        .code     (cfg_wdata[3:0]),
        .period   (acq_period_reg),
        .interval (wr_ival),
        .keep     (wr_keep)
    );

    // interval reloaded when the reading drops below threshold
    tars_interval #(.COUNTER_BITS(COUNTER_BITS)) u_rate_ival (
        .code     (rate_select_reg),
        .period   (acq_period_reg),
        .interval (rate_ival),
        .keep     (rate_keep)
    );

    // fast interval used while alerted; its code is never a keep code
    tars_interval #(.COUNTER_BITS(COUNTER_BITS)) u_fast_ival (
        .code     (tars_pkg::RATE_CODE_FAST),
        .period   (acq_period_reg),
        .interval (fast_ival),
        .keep     (fast_keep)
    );

    // handshake: input register parted from output register
    assign step     = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || step;
    assign in_fire  = in_valid && in_ready;

    assign out_valid    = out_valid_reg;
    assign acquire      = acquire_reg;
    assign transmit     = transmit_reg;
    assign report_alert = report_alert_reg;
    assign alert_now    = alert_now_reg;

    always_comb
    begin
        s1_valid_next = in_fire ? 1'b1 : (step ? 1'b0 : s1_valid_reg);
        if (step) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // config writes
    always_comb
    begin
        threshold_next     = threshold_reg;
        rate_select_next   = rate_select_reg;
        acq_period_next    = acq_period_reg;
        persist_count_next = persist_count_reg;
        check_window_next  = check_window_reg;
        if (cfg_we) begin
            case (cfg_index)
                tars_pkg::CFG_THRESHOLD:     threshold_next     = cfg_wdata;
                tars_pkg::CFG_RATE_SELECT:   rate_select_next   = cfg_wdata[3:0];
                tars_pkg::CFG_ACQ_PERIOD:    acq_period_next    = cfg_wdata;
                tars_pkg::CFG_PERSIST_COUNT: persist_count_next = cfg_wdata[7:0];
                tars_pkg::CFG_CHECK_WINDOW:  check_window_next  = cfg_wdata;
                default: ;
            endcase
        end
    end

    // one tick of the scheduler
    always_comb
    begin
        acq_counter_next     = acq_counter_reg;
        report_counter_next  = report_counter_reg;
        report_interval_next = report_interval_reg;
        persist_counter_next = persist_counter_reg;
        window_counter_next  = window_counter_reg;
        report_pending_next  = report_pending_reg;
        first_report_next    = first_report_reg;
        check_pending_next   = check_pending_reg;
        alert_next           = alert_reg;
        acquire_c            = 1'b0;
        transmit_c           = 1'b0;
        acq_inc              = '0;
        rc_inc               = '0;
        pc_inc               = '0;
        wc_inc               = '0;

        if (step) begin
            // acquisition pacing
            acq_inc = acq_counter_reg + CNT_ONE;
            acq_counter_next = acq_inc;
            if (CMP_W'(acq_period_reg) <= CMP_W'(acq_inc)) begin
                acquire_c           = 1'b1;
                acq_counter_next    = '0;
                report_pending_next = 1'b1;
                check_pending_next  = 1'b1;
                if (first_report_reg) begin
                    report_counter_next = FORCE_VAL;
                    first_report_next   = 1'b0;
                end
            end

            // report pacing
            rc_inc = report_counter_next + CNT_ONE;
            report_counter_next = rc_inc;
            if (report_interval_reg <= rc_inc) begin
                report_counter_next = '0;
                if (report_pending_next) begin
                    report_pending_next = 1'b0;
                    transmit_c          = 1'b1;
                end
            end

            // threshold check, once per acquisition
            if (check_pending_next) begin
                check_pending_next = 1'b0;
                if (threshold_reg <= level_reg) begin
                    pc_inc = persist_counter_reg + CNT_ONE;
                    persist_counter_next = pc_inc;
                    if (CMP_W'(persist_count_reg) <= CMP_W'(pc_inc)) begin
                        persist_counter_next = '0;
                        report_interval_next = fast_ival_reg;
                        report_counter_next  = FORCE_VAL;
                        alert_next           = 1'b1;
                        report_pending_next  = 1'b1;
                    end
                end else begin
                    alert_next = 1'b0;
                    if (!rate_keep_reg) begin
                        report_interval_next = rate_ival_reg;
                    end
                end
            end

            // persistence window
            wc_inc = window_counter_reg + CNT_ONE;
            if (persist_counter_next != '0) begin
                window_counter_next = wc_inc;
            end
            if (CMP_W'(check_window_reg) <= CMP_W'(window_counter_next)) begin
                window_counter_next  = '0;
                persist_counter_next = '0;
            end
        end else if (cfg_we && cfg_index == tars_pkg::CFG_RATE_SELECT && !wr_keep) begin
            // rate switch write loads the interval directly
            report_interval_next = wr_ival;
        end

        report_alert_c = transmit_c && alert_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            threshold_reg       <= 16'd6554;
            rate_select_reg     <= 4'd0;
            acq_period_reg      <= 16'd50;
            persist_count_reg   <= 8'd30;
            check_window_reg    <= 16'd2800;
            acq_counter_reg     <= '0;
            report_counter_reg  <= '0;
            report_interval_reg <= '0;
            persist_counter_reg <= '0;
            window_counter_reg  <= '0;
            report_pending_reg  <= 1'b0;
            first_report_reg    <= 1'b1;
            check_pending_reg   <= 1'b0;
            alert_reg           <= 1'b0;
            s1_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
        end else begin
            threshold_reg       <= threshold_next;
            rate_select_reg     <= rate_select_next;
            acq_period_reg      <= acq_period_next;
            persist_count_reg   <= persist_count_next;
            check_window_reg    <= check_window_next;
            acq_counter_reg     <= acq_counter_next;
            report_counter_reg  <= report_counter_next;
            report_interval_reg <= report_interval_next;
            persist_counter_reg <= persist_counter_next;
            window_counter_reg  <= window_counter_next;
            report_pending_reg  <= report_pending_next;
            first_report_reg    <= first_report_next;
            check_pending_reg   <= check_pending_next;
            alert_reg           <= alert_next;
            s1_valid_reg        <= s1_valid_next;
            out_valid_reg       <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            level_reg <= low_band_level;
        end
        if (step) begin
            acquire_reg      <= acquire_c;
            transmit_reg     <= transmit_c;
            report_alert_reg <= report_alert_c;
            alert_now_reg    <= alert_next;
        end
        // fast code is a table code, never a keep code
        rate_ival_reg <= rate_ival;
        rate_keep_reg <= rate_keep;
        fast_ival_reg <= fast_keep ? fast_ival_reg : fast_ival;
    end

    // checks
    `TARS_ASSERT_IMPLIES(a_alert_bit_needs_tx, clk, rst_n, out_valid_reg && report_alert_reg, transmit_reg)
    `TARS_ASSERT_IMPLIES(a_alert_arms_report, clk, rst_n, $rose(alert_reg), report_pending_reg)
    `TARS_ASSERT_IMPLIES(a_first_on_acquire, clk, rst_n, $fell(first_report_reg), out_valid_reg && acquire_reg)
    `TARS_ASSERT_NEXT(a_no_tick_no_count, clk, rst_n, !step, $stable(acq_counter_reg))

endmodule

>>> verif/tb_threshold_alarm_report_scheduler_top.sv
// testbench for threshold_alarm_report_scheduler_top: drives timer tick beats and
// register writes, predicts every result beat in a scoreboard class and compares it
// depends on tars_pkg and the scheduler rtl
`timescale 1ns / 1ps

typedef struct packed {
    logic acquire;
    logic transmit;
    logic report_alert;
    logic alert_now;
} tick_result_t;

class report_schedule_board;
    typedef logic [15:0] count_t;
    localparam count_t COUNT_MAX    = 16'hFFFF;
    localparam count_t COUNT_ONE    = count_t'(1);
    localparam count_t FORCED_COUNT = count_t'(tars_pkg::FORCE_LOAD);

    // register copies
    logic [15:0]          threshold;
    tars_pkg::rate_code_t rate_select;
    logic [15:0]          acq_period;
    logic [7:0]           persist_count;
    logic [15:0]          check_window;

    // scheduler state
    count_t acq_counter;
    count_t report_counter;
    count_t report_interval;
    count_t persist_counter;
    count_t window_counter;
    bit     report_pending;
    bit     first_report;
    bit     check_pending;
    bit     alert;

    int unsigned  factor_by_code[7];
    tick_result_t expected_ticks[$];
    int unsigned  error_count;
    int unsigned  checked_count;

    function new();
        factor_by_code = '{0, 15, 30, 60, 300, 600, 900};
        error_count    = 0;
        checked_count  = 0;
        threshold      = 16'd6554;
        rate_select    = '0;
        acq_period     = 16'd50;
        persist_count  = 8'd30;
        check_window   = 16'd2800;
        acq_counter    = '0;
        report_counter = '0;
        report_interval = '0;
        persist_counter = '0;
        window_counter = '0;
        report_pending = 1'b0;
        first_report   = 1'b1;
        check_pending  = 1'b0;
        alert          = 1'b0;
    endfunction

    function int unsigned pending_count();
        return expected_ticks.size();
    endfunction

    // period times factor, clipped at the counter maximum
    function count_t scaled_interval(int unsigned factor);
        longint unsigned product;
        product = longint'(acq_period) * longint'(factor);
        return (product > longint'(COUNT_MAX)) ? COUNT_MAX : count_t'(product);
    endfunction

    // codes above the max code leave the interval alone
    function void reload_rate_interval();
        if (rate_select < tars_pkg::RATE_CODE_MAX)
            report_interval = scaled_interval(factor_by_code[rate_select]);
        else if (rate_select == tars_pkg::RATE_CODE_MAX)
            report_interval = COUNT_MAX;
    endfunction

    function void write_reg(logic [tars_pkg::CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            tars_pkg::CFG_THRESHOLD:     threshold = data;
            tars_pkg::CFG_RATE_SELECT:
            begin
                rate_select = data[3:0];
                reload_rate_interval();
            end
            tars_pkg::CFG_ACQ_PERIOD:    acq_period = data;
            tars_pkg::CFG_PERSIST_COUNT: persist_count = data[7:0];
            tars_pkg::CFG_CHECK_WINDOW:  check_window = data;
            default: ;
        endcase
    endfunction

    // one accepted tick: advance the schedule and queue the result it causes
    function void note_tick(logic [15:0] level);
        tick_result_t want;
        bit           alert_before;
        want         = '0;
        alert_before = alert;

        acq_counter = acq_counter + COUNT_ONE;
        if (acq_period <= acq_counter)
        begin
            want.acquire   = 1'b1;
            acq_counter    = '0;
            report_pending = 1'b1;
            check_pending  = 1'b1;
            if (first_report)
            begin
                report_counter = FORCED_COUNT;
                first_report   = 1'b0;
            end
        end

        report_counter = report_counter + COUNT_ONE;
        if (report_interval <= report_counter)
        begin
            report_counter = '0;
            if (report_pending)
            begin
                report_pending = 1'b0;
                want.transmit  = 1'b1;
            end
        end

        if (check_pending)
        begin
            check_pending = 1'b0;
            if (threshold <= level)
            begin
                persist_counter = persist_counter + COUNT_ONE;
                if (count_t'(persist_count) <= persist_counter)
                begin
                    persist_counter = '0;
                    report_interval = scaled_interval(
                        factor_by_code[tars_pkg::RATE_CODE_FAST]);
                    report_counter  = FORCED_COUNT;
                    alert           = 1'b1;
                    report_pending  = 1'b1;
                end
            end
            else
            begin
                alert = 1'b0;
                reload_rate_interval();
            end
        end

        if (persist_counter != '0)
            window_counter = window_counter + COUNT_ONE;
        if (check_window <= window_counter)
        begin
            window_counter  = '0;
            persist_counter = '0;
        end

        want.report_alert = want.transmit & alert_before;
        want.alert_now    = alert;
        expected_ticks.push_back(want);
    endfunction

    function void check_tick(tick_result_t got);
        tick_result_t want;
        checked_count++;
        if (expected_ticks.size() == 0)
        begin
            error_count++;
            if (error_count <= 10)
                $display("result %0d: beat with nothing expected, got %b",
                         checked_count, got);
            return;
        end
        want = expected_ticks.pop_front();
        if (got.acquire !== want.acquire || got.transmit !== want.transmit ||
            got.report_alert !== want.report_alert || got.alert_now !== want.alert_now)
        begin
            error_count++;
            if (error_count <= 10)
                $display("result %0d: acquire/transmit/report_alert/alert_now exp %b%b%b%b got %b%b%b%b",
                         checked_count, want.acquire, want.transmit, want.report_alert,
                         want.alert_now, got.acquire, got.transmit, got.report_alert,
                         got.alert_now);
        end
    endfunction
endclass

module tb_threshold_alarm_report_scheduler_top;

    // input register plus output register
    localparam int PIPE_LATENCY   = 2;
    localparam int SETTLE_CYCLES  = PIPE_LATENCY + 1;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int IDLE_LIMIT     = 2000;
    localparam int RANDOM_PHASES  = 9;
    localparam int PHASE_TICKS    = 50;
    localparam int PRESSURE_PHASE = 3;

    // indexes past the end of the register list
    localparam logic [tars_pkg::CFG_IDX_W-1:0] CFG_SPARE_FIRST = 3'd5;
    localparam logic [tars_pkg::CFG_IDX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic [15:0]                     low_band_level;
    logic                            out_valid;
    logic                            out_ready;
    logic                            acquire;
    logic                            transmit;
    logic                            report_alert;
    logic                            alert_now;
    logic                            cfg_we;
    logic [tars_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [tars_pkg::CFG_DATA_W-1:0] cfg_wdata;

    report_schedule_board board;
    logic [15:0]          level_threshold;   // threshold of the current phase
    bit                   hold_off_request;
    int unsigned          quiet_cycles;

    threshold_alarm_report_scheduler_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .low_band_level (low_band_level),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .acquire        (acquire),
        .transmit       (transmit),
        .report_alert   (report_alert),
        .alert_now      (alert_now),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one tick beat and hold it until the block takes it
    task automatic send_tick(input logic [15:0] level);
        in_valid       <= 1'b1;
        low_band_level <= level;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_tick(level);
    endtask

    // directed beats back to back, valid dropped after the last one
    task automatic send_back_to_back(input logic [15:0] levels[$]);
        foreach (levels[i])
            send_tick(levels[i]);
        in_valid <= 1'b0;
    endtask

    // single register write; write enable stays high until the caller drops it
    task automatic write_reg(input logic [tars_pkg::CFG_IDX_W-1:0] idx,
                             input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        board.write_reg(idx, data);
    endtask

    // writes all five registers once the block has drained; the narrow registers
    // get random upper bits that the block must ignore
    task automatic reconfigure(input logic [15:0] thr, input logic [3:0] rate,
                               input logic [15:0] period, input logic [7:0] persist,
                               input logic [15:0] window);
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        write_reg(tars_pkg::CFG_THRESHOLD, thr);
        write_reg(tars_pkg::CFG_ACQ_PERIOD, period);
        write_reg(tars_pkg::CFG_RATE_SELECT, {12'($urandom()), rate});
        write_reg(tars_pkg::CFG_PERSIST_COUNT, {8'($urandom()), persist});
        write_reg(tars_pkg::CFG_CHECK_WINDOW, window);
        cfg_we <= 1'b0;
        // let the registered derived intervals settle after the writes
        repeat (SETTLE_CYCLES) @(posedge clk);
        level_threshold = thr;
    endtask

    // mostly at or above threshold so persistence builds up, some below to clear it
    function automatic logic [15:0] pick_level(input logic [15:0] thr);
        int unsigned roll;
        roll = $urandom_range(0, 9);
        if (roll < 6)
            return 16'($urandom_range(32'(thr), 65535));
        else if (roll < 9 && thr != 16'd0)
            return 16'($urandom_range(0, 32'(thr) - 1));
        return 16'($urandom());
    endfunction

    // bursts of beats with random gaps in between
    task automatic run_phase(input int unsigned tick_total);
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;
        sent = 0;
        while (sent < tick_total)
        begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                : $urandom_range(1, 10);
            for (int i = 0; i < burst && sent < tick_total; i++)
            begin
                send_tick(pick_level(level_threshold));
                sent++;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0 || sent == tick_total)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // result side: one comparison per accepted result beat
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_tick({acquire, transmit, report_alert, alert_now});
    end

    // receiver: ready runs and stalls of random length, sometimes a long clean run,
    // and one long hold-off on request so the pipeline fills and backs up
    initial
    begin
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_request = 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                repeat (($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12))
                    @(posedge clk);
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
        end
    end

    // watchdog: cycles without any beat on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    // main sequence
    initial
    begin
        logic [15:0] thr;
        logic [3:0]  rate;
        logic [15:0] period;
        logic [7:0]  persist;
        logic [15:0] window;

        board            = new();
        level_threshold  = 16'd6554;
        hold_off_request = 1'b0;
        rst_n            <= 1'b0;
        in_valid         <= 1'b0;
        low_band_level   <= '0;
        cfg_we           <= 1'b0;
        cfg_index        <= '0;
        cfg_wdata        <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset registers, no acquisition reached yet
        send_back_to_back('{16'hFFFF, 16'h0000, 16'h5555, 16'hAAAA});

        // slowest acquisition, rate code zero, longest persistence and window
        reconfigure(16'd6554, 4'd0, 16'hFFFF, 8'd255, 16'hFFFF);
        send_back_to_back('{16'd6554, 16'd6553});

        // acquisition on every tick, zero interval, zero persistence and window,
        // a code that keeps the previous interval
        reconfigure(16'h8000, 4'd15, 16'h0000, 8'd0, 16'h0000);
        send_back_to_back('{16'hFFFF, 16'h8000, 16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF});

        // zero threshold: every reading counts, saturated interval code
        reconfigure(16'h0000, tars_pkg::RATE_CODE_MAX, 16'd1, 8'd255, 16'hFFFF);
        send_back_to_back('{16'h0000, 16'h1234, 16'hFFFF});

        // top threshold, short persistence inside a short window, then writes
        // to indexes past the register list that must change nothing
        reconfigure(16'hFFFF, 4'd1, 16'd1, 8'd2, 16'd3);
        for (int idx = CFG_SPARE_FIRST; idx <= CFG_SPARE_LAST; idx++)
            write_reg(tars_pkg::CFG_IDX_W'(idx), 16'($urandom()));
        cfg_we <= 1'b0;
        @(posedge clk);
        send_back_to_back('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFE, 16'hFFFF, 16'hFFFF});

        // random phases: small periods and persistence so alerts and reports
        // come often, wide windows now and then
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            thr     = 16'($urandom());
            rate    = 4'($urandom_range(0, 15));
            period  = 16'($urandom_range(0, 4));
            persist = 8'($urandom_range(0, 5));
            window  = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                  : 16'($urandom_range(0, 40));
            reconfigure(thr, rate, period, persist, window);
            if (phase == PRESSURE_PHASE)
                hold_off_request = 1'b1;
            run_phase(PHASE_TICKS);
        end

        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.error_count == 0 && board.pending_count() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
